// ===== rtl/length_prefixed_request_parser_macros.svh =====
// Assertion macros shared by the request parser modules.
// Depends on nothing; included by the files that carry assertions.
`ifndef LENGTH_PREFIXED_REQUEST_PARSER_MACROS_SVH
`define LENGTH_PREFIXED_REQUEST_PARSER_MACROS_SVH

// Same-cycle implication, disabled during reset.
`define LPRP_ASSERT_IMP(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, disabled during reset.
`define LPRP_ASSERT_NXT(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== rtl/lprp_pkg.sv =====
// Types and constants of the length-prefixed request parser.
// No dependencies; imported by every module of the block.
package lprp_pkg;

  typedef enum logic [2:0] {
    PH_COUNT,
    PH_LEN,
    PH_PAYLOAD,
    PH_DONE,
    PH_DROP
  } phase_t;

  localparam logic [1:0] KIND_BYTE   = 2'd0;
  localparam logic [1:0] KIND_EMPTY  = 2'd1;
  localparam logic [1:0] KIND_ACCEPT = 2'd2;
  localparam logic [1:0] KIND_REJECT = 2'd3;

  localparam logic [1:0] FAULT_NONE      = 2'd0;
  localparam logic [1:0] FAULT_TRUNCATED = 2'd1;
  localparam logic [1:0] FAULT_TOO_MANY  = 2'd2;
  localparam logic [1:0] FAULT_TRAILING  = 2'd3;

  localparam logic [31:0] MAX_ARGS_RESET = 32'd200000;

  // Work for the back end: up to one argument result and one status result.
  typedef struct packed {
    logic        data_valid;
    logic [1:0]  data_kind;
    logic [31:0] data_index;
    logic [7:0]  data_byte;
    logic        data_end;
    logic        stat_valid;
    logic [1:0]  stat_kind;
    logic [1:0]  stat_fault;
    logic [31:0] stat_index;
  } rec_t;

endpackage

// ===== rtl/lprp_if.sv =====
// Request and result channel interfaces of the request parser.
// No dependencies; used by the top level and its front and back ends.
interface lprp_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] in_byte;
  logic       end_of_message;

  modport source (output valid, output in_byte, output end_of_message, input ready);
  modport sink (input valid, input in_byte, input end_of_message, output ready);
endinterface

interface lprp_out_if;
  logic        valid;
  logic        ready;
  logic [1:0]  kind;
  logic [1:0]  fault;
  logic [31:0] arg_index;
  logic [7:0]  out_byte;
  logic        arg_end;
  logic        last;

  modport source (output valid, output kind, output fault, output arg_index,
                  output out_byte, output arg_end, output last, input ready);
  modport sink (input valid, input kind, input fault, input arg_index,
                input out_byte, input arg_end, input last, output ready);
endinterface

// ===== rtl/lprp_front.sv =====
// Front end: parses request bytes and queues the results each byte causes.
// Depends on lprp_pkg, lprp_if.sv and the assertion macro header.
`include "length_prefixed_request_parser_macros.svh"

module lprp_front
  import lprp_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  logic        cfg_we,
  input  logic [31:0] cfg_wdata,
  lprp_in_if.sink     req,
  input  logic        fifo_full,
  output logic        push,
  output rec_t        push_rec
);

  phase_t      phase, phase_next;
  logic [1:0]  field_byte_count, field_byte_count_next;
  logic [31:0] field_shift, field_shift_next;
  logic [31:0] args_left, args_left_next;
  logic [31:0] payload_left, payload_left_next;
  logic [31:0] arg_counter, arg_counter_next;
  logic [1:0]  fault_code, fault_code_next;
  logic [31:0] max_args;
  logic [31:0] shifted;
  logic        field_full;
  logic        accept;
  rec_t        rec;

  assign req.ready = !fifo_full;
  assign accept    = req.valid && !fifo_full;
  assign push      = accept && (rec.data_valid || rec.stat_valid);
  assign push_rec  = rec;

  assign shifted    = {field_shift[23:0], req.in_byte};
  assign field_full = (field_byte_count == 2'd3);

  always_comb begin
    phase_next            = phase;
    field_byte_count_next = field_byte_count;
    field_shift_next      = field_shift;
    args_left_next        = args_left;
    payload_left_next     = payload_left;
    arg_counter_next      = arg_counter;
    fault_code_next       = fault_code;
    rec                   = '0;

    case (phase)
      PH_COUNT: begin
        field_byte_count_next = field_full ? 2'd0 : field_byte_count + 2'd1;
        field_shift_next      = field_full ? 32'd0 : shifted;
        if (field_full) begin
          if (shifted > max_args) begin
            fault_code_next = FAULT_TOO_MANY;
            phase_next      = PH_DROP;
          end else begin
            args_left_next   = shifted;
            arg_counter_next = 32'd0;
            phase_next       = (shifted == 32'd0) ? PH_DONE : PH_LEN;
          end
        end
      end
      PH_LEN: begin
        field_byte_count_next = field_full ? 2'd0 : field_byte_count + 2'd1;
        field_shift_next      = field_full ? 32'd0 : shifted;
        if (field_full) begin
          if (shifted == 32'd0) begin
            rec.data_valid   = 1'b1;
            rec.data_kind    = KIND_EMPTY;
            rec.data_index   = arg_counter;
            rec.data_end     = 1'b1;
            arg_counter_next = arg_counter + 32'd1;
            args_left_next   = args_left - 32'd1;
            phase_next       = (args_left == 32'd1) ? PH_DONE : PH_LEN;
          end else begin
            payload_left_next = shifted;
            phase_next        = PH_PAYLOAD;
          end
        end
      end
      PH_PAYLOAD: begin
        rec.data_valid    = 1'b1;
        rec.data_kind     = KIND_BYTE;
        rec.data_index    = arg_counter;
        rec.data_byte     = req.in_byte;
        rec.data_end      = (payload_left == 32'd1);
        payload_left_next = payload_left - 32'd1;
        if (payload_left == 32'd1) begin
          arg_counter_next = arg_counter + 32'd1;
          args_left_next   = args_left - 32'd1;
          phase_next       = (args_left == 32'd1) ? PH_DONE : PH_LEN;
        end
      end
      PH_DONE: begin
        fault_code_next = FAULT_TRAILING;
        phase_next      = PH_DROP;
      end
      default: begin
      end
    endcase

    // The final byte reports the status and returns the parser to its idle state.
    if (req.end_of_message) begin
      rec.stat_valid = 1'b1;
      rec.stat_index = arg_counter_next;
      if (fault_code_next != FAULT_NONE) begin
        rec.stat_kind  = KIND_REJECT;
        rec.stat_fault = fault_code_next;
      end else if (phase_next == PH_DONE) begin
        rec.stat_kind  = KIND_ACCEPT;
        rec.stat_fault = FAULT_NONE;
      end else begin
        rec.stat_kind  = KIND_REJECT;
        rec.stat_fault = FAULT_TRUNCATED;
      end
      phase_next            = PH_COUNT;
      field_byte_count_next = 2'd0;
      field_shift_next      = 32'd0;
      args_left_next        = 32'd0;
      payload_left_next     = 32'd0;
      arg_counter_next      = 32'd0;
      fault_code_next       = FAULT_NONE;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      max_args <= MAX_ARGS_RESET;
    end else if (cfg_we) begin
      max_args <= cfg_wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase            <= PH_COUNT;
      field_byte_count <= 2'd0;
      field_shift      <= 32'd0;
      args_left        <= 32'd0;
      payload_left     <= 32'd0;
      arg_counter      <= 32'd0;
      fault_code       <= FAULT_NONE;
    end else if (accept) begin
      phase            <= phase_next;
      field_byte_count <= field_byte_count_next;
      field_shift      <= field_shift_next;
      args_left        <= args_left_next;
      payload_left     <= payload_left_next;
      arg_counter      <= arg_counter_next;
      fault_code       <= fault_code_next;
    end
  end

  `LPRP_ASSERT_NXT(a_eom_clears, clk, rst, accept && req.end_of_message,
                   phase == PH_COUNT && fault_code == FAULT_NONE && arg_counter == 32'd0,
                   "parser state not cleared after the final byte of a request")
  `LPRP_ASSERT_IMP(a_fault_drops, clk, rst, fault_code != FAULT_NONE,
                   phase == PH_DROP, "fault recorded while not dropping")

endmodule

// ===== rtl/lprp_fifo.sv =====
// Short queue of parsed work between the front and back ends.
// Depends on lprp_pkg and the assertion macro header.
`include "length_prefixed_request_parser_macros.svh"

module lprp_fifo
  import lprp_pkg::*;
#(
  parameter int DEPTH = 4
) (
  input  logic clk,
  input  logic rst,
  input  logic push,
  input  rec_t push_rec,
  input  logic pop,
  output rec_t head,
  output logic full,
  output logic empty
);

  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);

  rec_t          entries [DEPTH];
  logic [AW-1:0] wr_ptr, rd_ptr;
  logic [CW-1:0] count;

  assign full  = (count == CW'(DEPTH));
  assign empty = (count == '0);
  assign head  = entries[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) begin
      entries[wr_ptr] <= push_rec;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == AW'(DEPTH - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == AW'(DEPTH - 1)) ? '0 : rd_ptr + 1'b1;
      end
      case ({push, pop})
        2'b10:   count <= count + 1'b1;
        2'b01:   count <= count - 1'b1;
        default: count <= count;
      endcase
    end
  end

  `LPRP_ASSERT_IMP(a_count_bound, clk, rst, 1'b1, count <= CW'(DEPTH),
                   "queue occupancy beyond its depth")
  `LPRP_ASSERT_IMP(a_no_pop_empty, clk, rst, pop, !empty, "pop from an empty queue")

endmodule

// ===== rtl/lprp_back.sv =====
// Back end: expands queued work into result items through an output register.
// Depends on lprp_pkg, lprp_if.sv and the assertion macro header.
`include "length_prefixed_request_parser_macros.svh"

module lprp_back
  import lprp_pkg::*;
(
  input  logic      clk,
  input  logic      rst,
  input  rec_t      head,
  input  logic      empty,
  output logic      pop,
  lprp_out_if.source res
);

  logic        second;
  logic        load;
  logic        use_data;
  logic        item_last;
  logic        out_valid;
  logic [1:0]  out_kind;
  logic [1:0]  out_fault;
  logic [31:0] out_index;
  logic [7:0]  out_data;
  logic        out_end;
  logic        out_last;

  assign load      = !empty && (!out_valid || res.ready);
  assign use_data  = !second && head.data_valid;
  assign item_last = !use_data || !head.stat_valid;
  assign pop       = load && item_last;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
      second    <= 1'b0;
    end else begin
      if (load) begin
        out_valid <= 1'b1;
        second    <= !item_last;
      end else if (res.ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      out_kind  <= use_data ? head.data_kind : head.stat_kind;
      out_fault <= use_data ? FAULT_NONE : head.stat_fault;
      out_index <= use_data ? head.data_index : head.stat_index;
      out_data  <= use_data ? head.data_byte : 8'd0;
      out_end   <= use_data ? head.data_end : 1'b0;
      out_last  <= item_last;
    end
  end

  assign res.valid     = out_valid;
  assign res.kind      = out_kind;
  assign res.fault     = out_fault;
  assign res.arg_index = out_index;
  assign res.out_byte  = out_data;
  assign res.arg_end   = out_end;
  assign res.last      = out_last;

  `LPRP_ASSERT_IMP(a_second_is_status, clk, rst, second && !empty, head.stat_valid,
                   "second result of a request byte is not a status")
  `LPRP_ASSERT_IMP(a_status_last, clk, rst,
                   out_valid && (out_kind == KIND_ACCEPT || out_kind == KIND_REJECT),
                   out_last, "status result not marked last")

endmodule

// ===== rtl/length_prefixed_request_parser.sv =====
// Length-prefixed request parser: one request byte per cycle in, results out.
// The first result of a byte passes through the queue and then the output register.
// Throughput: one byte per cycle; a final byte that closes an argument gives two
// results, sent one after the other; the input stalls only while the queue is full.
// Reset (synchronous, rst high) empties the queue, idles the parser, sets max_args to 200000.
// Depends on lprp_pkg, lprp_if.sv, lprp_front, lprp_fifo and lprp_back.
module length_prefixed_request_parser
  import lprp_pkg::*;
#(
  parameter int FIFO_DEPTH = 4
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        cfg_we,
  input  logic [31:0] cfg_wdata,
  lprp_in_if.sink     req_in,
  lprp_out_if.source  res_out
);

  rec_t push_rec;
  rec_t head;
  logic push, pop, full, empty;

  lprp_front u_front (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata),
    .req       (req_in),
    .fifo_full (full),
    .push      (push),
    .push_rec  (push_rec)
  );

  lprp_fifo #(
    .DEPTH (FIFO_DEPTH)
  ) u_fifo (
    .clk      (clk),
    .rst      (rst),
    .push     (push),
    .push_rec (push_rec),
    .pop      (pop),
    .head     (head),
    .full     (full),
    .empty    (empty)
  );

  lprp_back u_back (
    .clk   (clk),
    .rst   (rst),
    .head  (head),
    .empty (empty),
    .pop   (pop),
    .res   (res_out)
  );

endmodule

// ===== tb/tb_length_prefixed_request_parser.sv =====
`timescale 1ns / 1ps
// Self-checking testbench of length_prefixed_request_parser: random gaps and output
// stalls around a behavioral parser that predicts every result, checked in order.
// Depends on lprp_pkg, the lprp_in_if / lprp_out_if interfaces and the parser RTL.
module tb_length_prefixed_request_parser;
  import lprp_pkg::*;

  localparam int CYCLE_LIMIT   = 400000;
  localparam int SETTLE_CYCLES = 12;

  typedef struct packed {
    logic [1:0]  kind;
    logic [1:0]  fault;
    logic [31:0] arg_index;
    logic [7:0]  out_byte;
    logic        arg_end;
    logic        last;
  } parse_result_t;

  logic        clk;
  logic        rst;
  logic        cfg_we;
  logic [31:0] cfg_wdata;

  lprp_in_if  req_if ();
  lprp_out_if res_if ();

  length_prefixed_request_parser DUT (
    .clk      (clk),
    .rst      (rst),
    .cfg_we   (cfg_we),
    .cfg_wdata(cfg_wdata),
    .req_in   (req_if),
    .res_out  (res_if)
  );

  // Shadow parser state.
  phase_t      parse_phase;
  logic [1:0]  field_cnt;
  logic [31:0] field_acc;
  logic [31:0] args_left;
  logic [31:0] payload_left;
  logic [31:0] arg_idx;
  logic [1:0]  fault_code;
  logic [31:0] max_args_model;

  parse_result_t expected_results[$];
  parse_result_t want;
  logic [7:0]    msg_bytes[$];

  bit stall_en        = 1'b1;
  int hold_off_cycles = 0;
  int mismatches      = 0;
  int bytes_sent      = 0;
  int cycle_count     = 0;

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  function automatic void clear_parse();
    parse_phase  = PH_COUNT;
    field_cnt    = 2'd0;
    field_acc    = 32'd0;
    args_left    = 32'd0;
    payload_left = 32'd0;
    arg_idx      = 32'd0;
    fault_code   = FAULT_NONE;
  endfunction

  function automatic void close_argument();
    arg_idx     = arg_idx + 32'd1;
    args_left   = args_left - 32'd1;
    parse_phase = (args_left == 32'd0) ? PH_DONE : PH_LEN;
  endfunction

  // Advances the shadow parser by one byte and queues the results it causes.
  function automatic void parse_byte(input logic [7:0] b, input logic eom);
    parse_result_t produced[2];
    int            n;
    int            i;
    logic [31:0]   word;
    logic          full;
    n    = 0;
    word = {field_acc[23:0], b};
    full = (field_cnt == 2'd3);
    case (parse_phase)
      PH_COUNT, PH_LEN: begin
        field_acc = full ? 32'd0 : word;
        field_cnt = field_cnt + 2'd1;
        if (full && parse_phase == PH_COUNT) begin
          if (word > max_args_model) begin
            fault_code  = FAULT_TOO_MANY;
            parse_phase = PH_DROP;
          end else begin
            args_left   = word;
            arg_idx     = 32'd0;
            parse_phase = (word == 32'd0) ? PH_DONE : PH_LEN;
          end
        end else if (full && word == 32'd0) begin
          produced[n] = '{KIND_EMPTY, FAULT_NONE, arg_idx, 8'd0, 1'b1, 1'b0};
          n++;
          close_argument();
        end else if (full) begin
          payload_left = word;
          parse_phase  = PH_PAYLOAD;
        end
      end
      PH_PAYLOAD: begin
        produced[n] = '{KIND_BYTE, FAULT_NONE, arg_idx, b, payload_left == 32'd1, 1'b0};
        n++;
        payload_left = payload_left - 32'd1;
        if (payload_left == 32'd0) close_argument();
      end
      PH_DONE: begin
        fault_code  = FAULT_TRAILING;
        parse_phase = PH_DROP;
      end
      default: begin
      end
    endcase
    if (eom) begin
      if (fault_code != FAULT_NONE)
        produced[n] = '{KIND_REJECT, fault_code, arg_idx, 8'd0, 1'b0, 1'b0};
      else if (parse_phase == PH_DONE)
        produced[n] = '{KIND_ACCEPT, FAULT_NONE, arg_idx, 8'd0, 1'b0, 1'b0};
      else
        produced[n] = '{KIND_REJECT, FAULT_TRUNCATED, arg_idx, 8'd0, 1'b0, 1'b0};
      n++;
      clear_parse();
    end
    if (n > 0) produced[n - 1].last = 1'b1;
    for (i = 0; i < n; i++) expected_results = {expected_results, produced[i]};
  endfunction

  function automatic void check_field(input string name, input logic [31:0] exp_val,
                                      input logic [31:0] got_val);
    if (got_val !== exp_val) begin
      $error("%s: expected 0x%0h, got 0x%0h", name, exp_val, got_val);
      mismatches++;
    end
  endfunction

  function automatic void queue_byte(input logic [7:0] b);
    msg_bytes = {msg_bytes, b};
  endfunction

  function automatic void add_word(input logic [31:0] w);
    queue_byte(w[31:24]);
    queue_byte(w[23:16]);
    queue_byte(w[15:8]);
    queue_byte(w[7:0]);
  endfunction

  // Builds one message: mostly well formed, some cut short, some with extra
  // bytes, some with huge count or length fields, some plain noise.
  function automatic void compose_request();
    int unsigned style;
    int unsigned nargs;
    int unsigned len;
    int unsigned a;
    int unsigned keep;
    style = $urandom_range(0, 9);
    if (style == 9) begin
      repeat ($urandom_range(1, 6)) queue_byte(8'($urandom));
      return;
    end
    if (style == 8 && $urandom_range(0, 1) == 1) nargs = $urandom;
    else if ($urandom_range(0, 7) == 0) nargs = $urandom_range(5, 8);
    else nargs = $urandom_range(0, 4);
    add_word(nargs);
    for (a = 0; a < nargs && a < 10; a++) begin
      if (style == 8 && a == 0) len = $urandom | 32'h100;
      else if ($urandom_range(0, 5) == 0) len = $urandom_range(5, 24);
      else len = $urandom_range(0, 4);
      add_word(len);
      if (len > 64) begin
        // Far too long to finish: the message ends inside the payload.
        repeat ($urandom_range(0, 5)) queue_byte(8'($urandom));
        break;
      end
      repeat (len) queue_byte(8'($urandom));
    end
    if (style == 6) begin
      keep = $urandom_range(1, msg_bytes.size() - 1);
      while (msg_bytes.size() > keep) void'(msg_bytes.pop_back());
    end else if (style == 7) begin
      repeat ($urandom_range(1, 3)) queue_byte(8'($urandom));
    end
  endfunction

  task automatic push_byte(input logic [7:0] b, input logic eom);
    if (stall_en && $urandom_range(0, 3) == 0) begin
      req_if.valid <= 1'b0;
      repeat ($urandom_range(1, 5)) @(posedge clk);
    end
    req_if.valid          <= 1'b1;
    req_if.in_byte        <= b;
    req_if.end_of_message <= eom;
    do @(posedge clk); while (!req_if.ready);
    parse_byte(b, eom);
    bytes_sent++;
  endtask

  task automatic send_message();
    int i;
    for (i = 0; i < msg_bytes.size(); i++) push_byte(msg_bytes[i], i == msg_bytes.size() - 1);
    msg_bytes.delete();
  endtask

  // Called right after the last request is taken, so valid drops on that edge.
  task automatic settle();
    req_if.valid <= 1'b0;
    while (expected_results.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic set_max_args(input logic [31:0] value);
    settle();
    cfg_wdata <= value;
    cfg_we    <= 1'b1;
    @(posedge clk);
    cfg_we         <= 1'b0;
    max_args_model  = value;
  endtask

  task automatic test_directed_cases();
    queue_byte(8'h5A);
    send_message();
    add_word(32'd0);
    send_message();
    add_word(32'd0);
    queue_byte(8'hFF);
    send_message();
    // The final byte closes an empty argument and also carries the status.
    add_word(32'd1);
    add_word(32'd0);
    send_message();
    add_word(32'd1);
    add_word(32'd1);
    queue_byte(8'hFF);
    send_message();
    add_word(32'hFFFF_FFFF);
    queue_byte(8'h00);
    send_message();
    settle();
  endtask

  task automatic test_max_args_settings();
    logic [31:0] limits[6];
    int          k;
    int          target;
    limits    = '{32'd0, 32'd1, 32'd3, 32'hFFFF_FFFF, 32'd2, MAX_ARGS_RESET};
    limits[4] = $urandom_range(2, 6);
    for (k = 0; k < 6; k++) begin
      set_max_args(limits[k]);
      target = bytes_sent + 110;
      while (bytes_sent < target) begin
        compose_request();
        send_message();
      end
    end
    settle();
  endtask

  task automatic test_output_hold_off();
    hold_off_cycles = 80;
    add_word(32'd2);
    add_word(32'd30);
    repeat (30) queue_byte(8'($urandom));
    add_word(32'd0);
    send_message();
    settle();
  endtask

  task automatic test_unstalled_stream();
    int target;
    stall_en = 1'b0;
    target   = bytes_sent + 60;
    while (bytes_sent < target) begin
      compose_request();
      send_message();
    end
    settle();
  endtask

  // Result side: random stalls, plus one long hold-off when a test asks for it.
  initial begin
    res_if.ready <= 1'b0;
    forever begin
      @(posedge clk);
      if (hold_off_cycles > 0) begin
        res_if.ready <= 1'b0;
        repeat (hold_off_cycles) @(posedge clk);
        hold_off_cycles = 0;
      end else if (stall_en && $urandom_range(0, 3) == 0) begin
        res_if.ready <= 1'b0;
        repeat ($urandom_range(1, 5)) @(posedge clk);
      end
      res_if.ready <= 1'b1;
    end
  end

  always @(posedge clk) begin
    if (!rst && res_if.valid && res_if.ready) begin
      if (expected_results.size() == 0) begin
        $error("unexpected result: kind %0d index %0d byte 0x%0h", res_if.kind,
               res_if.arg_index, res_if.out_byte);
        mismatches++;
      end else begin
        want = expected_results.pop_front();
        check_field("kind", want.kind, res_if.kind);
        check_field("fault", want.fault, res_if.fault);
        check_field("arg_index", want.arg_index, res_if.arg_index);
        check_field("out_byte", want.out_byte, res_if.out_byte);
        check_field("arg_end", want.arg_end, res_if.arg_end);
        check_field("last", want.last, res_if.last);
      end
    end
  end

  initial begin
    while (cycle_count < CYCLE_LIMIT) begin
      @(posedge clk);
      cycle_count++;
    end
    $display("TB_ERROR");
    $finish;
  end

  initial begin
    rst                   <= 1'b1;
    cfg_we                <= 1'b0;
    cfg_wdata             <= 32'd0;
    req_if.valid          <= 1'b0;
    req_if.in_byte        <= 8'd0;
    req_if.end_of_message <= 1'b0;
    max_args_model         = MAX_ARGS_RESET;
    clear_parse();
    repeat (9) @(posedge clk);
    rst <= 1'b0;

    test_directed_cases();
    test_max_args_settings();
    test_output_hold_off();
    test_unstalled_stream();

    if (expected_results.size() != 0) begin
      $error("%0d results never arrived", expected_results.size());
      mismatches++;
    end
    if (mismatches == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule

// ===== filelist.f =====
+incdir+rtl
rtl/lprp_pkg.sv
rtl/lprp_if.sv
rtl/lprp_front.sv
rtl/lprp_fifo.sv
rtl/lprp_back.sv
rtl/length_prefixed_request_parser.sv
tb/tb_length_prefixed_request_parser.sv
